### rtl/imu_sample_time_aligner_top_macros.svh
// assertion macros for the imu sample time aligner
// used by the top level only, expects i_clk and i_rst_n in scope
`ifndef IMU_SAMPLE_TIME_ALIGNER_TOP_MACROS_SVH
`define IMU_SAMPLE_TIME_ALIGNER_TOP_MACROS_SVH

// same-cycle implication
`define ISTA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ista check failed");

// next-cycle implication
`define ISTA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ista check failed");

`endif

### rtl/ista_pkg.sv
// shared types, constants and ring helpers for the imu sample time aligner
// no dependencies
package ista_pkg;

    localparam int RING_DEPTH   = 64;
    localparam int SEARCH_LIMIT = 32;
    localparam int IDX_W        = $clog2(RING_DEPTH);
    localparam int CNT_W        = $clog2(SEARCH_LIMIT + 1);
    localparam int NVALS        = 7;
    localparam int KIDX_W       = $clog2(NVALS);
    localparam int TIME_W       = 48;
    localparam int VAL_W        = 32;
    localparam int PERIOD_W     = 20;
    localparam int GAP_W        = PERIOD_W + 2;   // three periods
    localparam int DEN_W        = PERIOD_W + 3;   // six periods
    localparam int NUM_W        = GAP_W + 16;     // gap in q22.16
    localparam int WIN_W        = TIME_W + 2;
    localparam int ENTRY_W      = TIME_W + NVALS * VAL_W;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(4000);

    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [1:0] ST_INTERP = 2'd0;
    localparam logic [1:0] ST_PASS   = 2'd1;
    localparam logic [1:0] ST_FAIL   = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]           stamp;
        logic [NVALS-1:0][VAL_W-1:0] vals;
    } t_entry;

    typedef struct packed {
        logic [1:0]                  status;
        logic [NVALS-1:0][VAL_W-1:0] vals;
    } t_res;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_cmd;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(RING_DEPTH - 1) : i - IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

endpackage

### rtl/ista_req_if.sv
// request channel: store or query items
// depends on ista_pkg
interface ista_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [ista_pkg::TIME_W-1:0]         stamp;
    logic signed [ista_pkg::VAL_W-1:0]   rate_x;
    logic signed [ista_pkg::VAL_W-1:0]   rate_y;
    logic signed [ista_pkg::VAL_W-1:0]   rate_z;
    logic signed [ista_pkg::VAL_W-1:0]   height;
    logic signed [ista_pkg::VAL_W-1:0]   roll_angle;
    logic signed [ista_pkg::VAL_W-1:0]   pitch_angle;
    logic signed [ista_pkg::VAL_W-1:0]   yaw_angle;

    modport source (output valid, req_type, stamp, rate_x, rate_y, rate_z, height,
                    roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink   (input valid, req_type, stamp, rate_x, rate_y, rate_z, height,
                    roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

### rtl/ista_res_if.sv
// result channel: aligned values and status
// depends on ista_pkg
interface ista_res_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [ista_pkg::VAL_W-1:0]   out_rate_x;
    logic signed [ista_pkg::VAL_W-1:0]   out_rate_y;
    logic signed [ista_pkg::VAL_W-1:0]   out_rate_z;
    logic signed [ista_pkg::VAL_W-1:0]   out_height;
    logic signed [ista_pkg::VAL_W-1:0]   out_roll;
    logic signed [ista_pkg::VAL_W-1:0]   out_pitch;
    logic signed [ista_pkg::VAL_W-1:0]   out_yaw;

    modport source (output valid, status, out_rate_x, out_rate_y, out_rate_z, out_height,
                    out_roll, out_pitch, out_yaw, input ready);
    modport sink   (input valid, status, out_rate_x, out_rate_y, out_rate_z, out_height,
                    out_roll, out_pitch, out_yaw, output ready);
endinterface

### rtl/ista_cfg_if.sv
// configuration write channel for the sample period
// depends on ista_pkg
interface ista_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ista_pkg::PERIOD_W-1:0]     sample_period;

    modport source (output valid, sample_period, input ready);
    modport sink   (input valid, sample_period, output ready);
endinterface

### rtl/ista_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module ista_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/ista_div.sv
// restoring divider for the interpolation fraction, one quotient bit per cycle
// depends on ista_pkg
module ista_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ista_pkg::t_div_cmd  i_cmd,
    output ista_pkg::t_div_rsp  o_rsp
);
    localparam int BCNT_W = $clog2(ista_pkg::NUM_W);

    logic                          r_busy;
    logic [BCNT_W-1:0]             r_cnt;
    logic [ista_pkg::NUM_W-1:0]    r_num;
    logic [ista_pkg::DEN_W-1:0]    r_den;
    logic [ista_pkg::DEN_W-1:0]    r_rem;
    logic                          r_done;
    logic [ista_pkg::DEN_W:0]      shifted;
    logic                          qbit;

    always_comb begin
        shifted = {r_rem, r_num[ista_pkg::NUM_W-1]};
        qbit    = (shifted >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + BCNT_W'(1);
                if (r_cnt == BCNT_W'(ista_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_num <= i_cmd.num;
            r_den <= i_cmd.den;
            r_rem <= '0;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits the divisor width
            r_rem <= qbit ? ista_pkg::DEN_W'(shifted - {1'b0, r_den})
                          : shifted[ista_pkg::DEN_W-1:0];
            r_num <= {r_num[ista_pkg::NUM_W-2:0], qbit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;
endmodule

### rtl/imu_sample_time_aligner_top.sv
// store: written to the ring on acceptance, back to back while idle. query: read and check
// states per search step (1 to 32 steps), entry reads and window checks, an output state,
// plus the divider and a multiply and accumulate step per value when interpolating; the
// output state waits while the result register is held, then idle before the next request
// synchronous active-low reset: period 4000, newest slot 0, all ring slots read as zero
// through per-slot valid bits; the ring memory itself is not cleared.
`include "imu_sample_time_aligner_top_macros.svh"

module imu_sample_time_aligner_top (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ista_req_if.sink   i_req,
    ista_cfg_if.sink   i_cfg,
    ista_res_if.source o_res
);
    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_SRD  = 12'b0000_0000_0010,
        S_SCHK = 12'b0000_0000_0100,
        S_RD0  = 12'b0000_0000_1000,
        S_L0   = 12'b0000_0001_0000,
        S_RD1  = 12'b0000_0010_0000,
        S_L1   = 12'b0000_0100_0000,
        S_EVAL = 12'b0000_1000_0000,
        S_DIV  = 12'b0001_0000_0000,
        S_MUL  = 12'b0010_0000_0000,
        S_ACC  = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } t_state;

    t_state                              r_state;
    logic [ista_pkg::PERIOD_W-1:0]       r_period;
    logic [ista_pkg::IDX_W-1:0]          r_newest;
    logic [ista_pkg::RING_DEPTH-1:0]     r_vld;
    logic [ista_pkg::IDX_W-1:0]          r_idx;
    logic [ista_pkg::CNT_W-1:0]          r_n;
    logic [ista_pkg::TIME_W-1:0]         r_q;
    ista_pkg::t_entry                    r_e0;
    ista_pkg::t_entry                    r_e1;
    logic                                r_fneg;
    logic [ista_pkg::NUM_W-1:0]          r_frac;
    logic [ista_pkg::KIDX_W-1:0]         r_k;
    logic [54:0]                         r_phi;
    logic [48:0]                         r_plo;
    logic                                r_pneg;
    ista_pkg::t_res                      r_res;
    ista_pkg::t_res                      r_out;
    logic                                r_out_valid;

    logic                                req_fire;
    logic                                out_load;
    logic                                ram_we;
    logic [ista_pkg::IDX_W-1:0]          ram_waddr;
    ista_pkg::t_entry                    ram_wdata;
    ista_pkg::t_entry                    ram_rdata;
    ista_pkg::t_entry                    rd_entry;
    ista_pkg::t_div_cmd                  div_cmd;
    ista_pkg::t_div_rsp                  div_rsp;

    // window and decision terms
    logic [ista_pkg::GAP_W-1:0]          per3;
    logic [ista_pkg::WIN_W-1:0]          q_x;
    logic [ista_pkg::WIN_W-1:0]          t0_x;
    logic [ista_pkg::WIN_W-1:0]          t1_x;
    logic                                t0_in;
    logic                                t1_in;
    logic                                do_interp;
    logic                                do_pass;
    logic [ista_pkg::TIME_W-1:0]         gap_mag;
    logic                                gap_neg;

    // blend terms
    logic signed [32:0]                  vdiff;
    logic [32:0]                         bmag;
    logic [55:0]                         mag_m;
    logic signed [57:0]                  v0_x;
    logic signed [57:0]                  sum_r;
    logic [ista_pkg::VAL_W-1:0]          sat_r;

    assign req_fire    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    // store path
    assign ram_we    = req_fire && (i_req.req_type == ista_pkg::REQ_STORE);
    assign ram_waddr = ista_pkg::ring_next(r_newest);
    always_comb begin
        ram_wdata.stamp   = i_req.stamp;
        ram_wdata.vals[0] = i_req.rate_x;
        ram_wdata.vals[1] = i_req.rate_y;
        ram_wdata.vals[2] = i_req.rate_z;
        ram_wdata.vals[3] = i_req.height;
        ram_wdata.vals[4] = i_req.roll_angle;
        ram_wdata.vals[5] = i_req.pitch_angle;
        ram_wdata.vals[6] = i_req.yaw_angle;
    end

    ista_ram #(
        .WIDTH (ista_pkg::ENTRY_W),
        .DEPTH (ista_pkg::RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // slot never written reads as zero
    assign rd_entry = r_vld[r_idx] ? ram_rdata : '0;

    ista_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        per3      = ista_pkg::GAP_W'(r_period) + ista_pkg::GAP_W'({r_period, 1'b0});
        q_x       = ista_pkg::WIN_W'(r_q);
        t0_x      = ista_pkg::WIN_W'(r_e0.stamp);
        t1_x      = ista_pkg::WIN_W'(r_e1.stamp);
        t0_in     = (t0_x + ista_pkg::WIN_W'(per3) >= q_x) && (t0_x <= q_x + ista_pkg::WIN_W'(per3));
        t1_in     = (t1_x + ista_pkg::WIN_W'(per3) >= q_x) && (t1_x <= q_x + ista_pkg::WIN_W'(per3));
        gap_neg   = (r_e0.stamp > r_q);
        gap_mag   = gap_neg ? (r_e0.stamp - r_q) : (r_q - r_e0.stamp);
        do_interp = t0_in && (r_e0.stamp < r_e1.stamp) && t1_in;
        do_pass   = t0_in && !gap_neg && (gap_mag <= ista_pkg::TIME_W'(r_period));

        div_cmd.start = (r_state == S_EVAL) && do_interp;
        div_cmd.num   = {gap_mag[ista_pkg::GAP_W-1:0], 16'd0};
        div_cmd.den   = ista_pkg::DEN_W'(r_e1.stamp - r_e0.stamp);
    end

    always_comb begin
        vdiff = 33'(signed'(r_e1.vals[r_k])) - 33'(signed'(r_e0.vals[r_k]));
        bmag  = vdiff[32] ? 33'(-vdiff) : 33'(vdiff);
        mag_m = 56'(r_phi) + 56'(r_plo >> 16);
        v0_x  = 58'(signed'(r_e0.vals[r_k]));
        sum_r = r_pneg ? (v0_x - signed'({2'b00, mag_m})) : (v0_x + signed'({2'b00, mag_m}));
        if (sum_r > 58'sd2147483647) begin
            sat_r = 32'h7FFF_FFFF;
        end else if (sum_r < -58'sd2147483648) begin
            sat_r = 32'h8000_0000;
        end else begin
            sat_r = sum_r[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= ista_pkg::PERIOD_RESET;
            r_newest    <= '0;
            r_vld       <= '0;
            r_idx       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_period <= i_cfg.sample_period;
            end
            if (ram_we) begin
                r_newest           <= ram_waddr;
                r_vld[ram_waddr]   <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (req_fire && i_req.req_type == ista_pkg::REQ_QUERY) begin
                        r_idx   <= r_newest;
                        r_n     <= '0;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    r_state <= S_SCHK;
                end
                S_SCHK: begin
                    if (rd_entry.stamp <= r_q) begin
                        r_state <= S_RD0;
                    end else if (r_n == ista_pkg::CNT_W'(ista_pkg::SEARCH_LIMIT - 1)) begin
                        // search ran out: fall back to the slot one further back
                        r_idx   <= ista_pkg::ring_prev(r_idx);
                        r_state <= S_RD0;
                    end else begin
                        r_idx   <= ista_pkg::ring_prev(r_idx);
                        r_n     <= r_n + ista_pkg::CNT_W'(1);
                        r_state <= S_SRD;
                    end
                end
                S_RD0: begin
                    r_state <= S_L0;
                end
                S_L0: begin
                    r_idx   <= ista_pkg::ring_next(r_idx);
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_state <= S_L1;
                end
                S_L1: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (do_interp) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_k     <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_k == ista_pkg::KIDX_W'(ista_pkg::NVALS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= r_k + ista_pkg::KIDX_W'(1);
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_q <= i_req.stamp;
        end
        if (r_state == S_L0) begin
            r_e0 <= rd_entry;
        end
        if (r_state == S_L1) begin
            r_e1 <= rd_entry;
        end
        if (r_state == S_EVAL) begin
            r_fneg <= gap_neg;
            if (do_interp) begin
                r_res.status <= ista_pkg::ST_INTERP;
            end else if (do_pass) begin
                r_res.status <= ista_pkg::ST_PASS;
                r_res.vals   <= r_e0.vals;
            end else begin
                r_res.status <= ista_pkg::ST_FAIL;
                r_res.vals   <= '0;
            end
        end
        if (r_state == S_DIV && div_rsp.done) begin
            r_frac <= div_rsp.quot;
        end
        if (r_state == S_MUL) begin
            r_phi  <= {33'd0, r_frac[ista_pkg::NUM_W-1:16]} * {22'd0, bmag};
            r_plo  <= {33'd0, r_frac[15:0]} * {16'd0, bmag};
            r_pneg <= vdiff[32] ^ r_fneg;
        end
        if (r_state == S_ACC) begin
            r_res.vals[r_k] <= sat_r;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out.status;
    assign o_res.out_rate_x = r_out.vals[0];
    assign o_res.out_rate_y = r_out.vals[1];
    assign o_res.out_rate_z = r_out.vals[2];
    assign o_res.out_height = r_out.vals[3];
    assign o_res.out_roll   = r_out.vals[4];
    assign o_res.out_pitch  = r_out.vals[5];
    assign o_res.out_yaw    = r_out.vals[6];

    `ISTA_ASSERT_NXT(a_store_advances, ram_we, r_newest == ista_pkg::ring_next($past(r_newest)))
    `ISTA_ASSERT_NXT(a_done_loads_out, out_load, r_out_valid && r_state == S_IDLE)
    `ISTA_ASSERT_IMP(a_div_done_in_div, div_rsp.done, r_state == S_DIV)
    `ISTA_ASSERT_IMP(a_search_bound, r_state == S_SCHK,
                     r_n <= ista_pkg::CNT_W'(ista_pkg::SEARCH_LIMIT - 1))
endmodule
